/* design/lscp_pkg.sv */
`timescale 1ns / 1ps

package lscp_pkg;

    // Block sizing
    localparam int CHANNELS  = 16;
    localparam int TICK_BITS = 16;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W     = (TICK_BITS > 16) ? TICK_BITS : 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TRIP_DELAY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_TH_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TH_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_TH_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TH_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART_MASK   = 3'd5;

    // Channel modes
    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_ON    = 3'd1;
    localparam logic [2:0] MODE_OC    = 3'd2;
    localparam logic [2:0] MODE_FAULT = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;
    localparam logic [2:0] MODE_OPEN  = 3'd5;

    // Actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_ON    = 3'd1;
    localparam logic [2:0] ACT_OFF   = 3'd2;
    localparam logic [2:0] ACT_OC    = 3'd3;
    localparam logic [2:0] ACT_OPEN  = 3'd4;
    localparam logic [2:0] ACT_FAULT = 3'd5;
    localparam logic [2:0] ACT_CLEAR = 3'd6;

    typedef struct packed {
        logic [3:0] channel;
        logic [7:0] current;
        logic       enable_request;
        logic       low_current_class;
        logic [7:0] fuse_limit;
    } sample_t;

    typedef struct packed {
        logic [3:0] channel_out;
        logic [2:0] mode;
        logic [2:0] action;
        logic       drive_on;
        logic       channel_error;
        logic       any_error;
    } result_t;

    typedef struct packed {
        logic [15:0] trip_delay;
        logic [7:0]  fault_threshold_high;
        logic [7:0]  open_threshold_high;
        logic [7:0]  fault_threshold_low;
        logic [7:0]  open_threshold_low;
        logic [15:0] restart_mask;
    } cfg_t;

    typedef struct packed {
        logic [2:0]           mode;
        logic [2:0]           action;
        logic [TICK_BITS-1:0] ticks;
        logic                 err;
    } upd_t;

endpackage

/* design/load_switch_channel_protection.sv */
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Word
// ----------+-----------+----------------------+-----------------------------
// sample    | in        | sample_valid / stall | channel, current, enable,
//           |           |                      | class, limit
// result    | out       | result_valid / stall | channel, mode, action, drive,
//           |           |                      | channel error, any error
// cfg       | in        | cfg_valid / ready    | register index, write data
//
// One word per cycle sustained while result_stall stays low. A sample taken
// into the sample register goes through the per-channel compare-and-update
// into the result register, from which its result word leaves.
// Reset loads the register defaults and puts every channel off with its
// tick counter and error bit cleared.
// result_stall holds the result register; sample_stall rises only while both
// the sample register and the result register are full and the result is held.

module load_switch_channel_protection (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  lscp_pkg::sample_t                  sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output lscp_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lscp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lscp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lscp_pkg::*;

    cfg_t                 cfg;

    // Sample stage
    logic                 s1_valid_reg;
    sample_t              s1_reg;

    // Per-channel state
    logic [2:0]           mode_reg  [CHANNELS];
    logic [TICK_BITS-1:0] ticks_reg [CHANNELS];
    logic [CHANNELS-1:0]  err_reg;
    logic [CHANNELS-1:0]  err_next;

    // Result stage
    logic                 result_valid_reg;
    result_t              result_reg;
    result_t              result_next;

    logic                 advance;
    logic                 take;
    logic                 commit;
    logic                 in_range;
    logic [CH_IDX_W-1:0]  chan_idx;
    upd_t                 upd;

    // Registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    lscp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register frees when empty or being taken this edge
    assign advance      = !result_valid_reg || !result_stall;
    assign sample_stall = s1_valid_reg && !advance;
    assign take         = sample_valid && !sample_stall;
    assign commit       = s1_valid_reg && advance;

    // Channels past the populated count leave state untouched
    assign in_range = int'(s1_reg.channel) < CHANNELS;
    assign chan_idx = CH_IDX_W'(s1_reg.channel);

    lscp_step u_step (
        .cfg       (cfg),
        .item      (s1_reg),
        .cur_mode  (mode_reg[chan_idx]),
        .cur_ticks (ticks_reg[chan_idx]),
        .cur_err   (err_reg[chan_idx]),
        .upd       (upd)
    );

    // any_error reflects the error bits after this word's update
    always_comb
    begin
        err_next = err_reg;
        if (in_range)
        begin
            err_next[chan_idx] = upd.err;
        end
    end

    always_comb
    begin
        result_next.channel_out = s1_reg.channel;
        result_next.any_error   = |err_next;
        if (in_range)
        begin
            result_next.mode          = upd.mode;
            result_next.action        = upd.action;
            result_next.drive_on      = (upd.mode == MODE_ON);
            result_next.channel_error = upd.err;
        end
        else
        begin
            result_next.mode          = MODE_OFF;
            result_next.action        = ACT_NONE;
            result_next.drive_on      = 1'b0;
            result_next.channel_error = 1'b0;
        end
    end

    // Sample register: load on accept, drop once moved on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= sample;
        end
    end

    // Channel state: write back on commit, so the next word sees it at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                mode_reg[i]  <= MODE_OFF;
                ticks_reg[i] <= '0;
            end
            err_reg <= '0;
        end
        else if (commit && in_range)
        begin
            mode_reg[chan_idx]  <= upd.mode;
            ticks_reg[chan_idx] <= upd.ticks;
            err_reg             <= err_next;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // A set channel error bit must show in the summary flag
    a_err_in_any: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.channel_error |-> result.any_error)
        else $error("channel error without any_error");

    // Overcurrent and fault modes always carry the latched error
    a_trip_latched: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.mode == MODE_OC || result.mode == MODE_FAULT)
        |-> result.channel_error)
        else $error("trip mode without latched error");

    // Back-pressure only when both stages are full and the result is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> s1_valid_reg && result_valid && result_stall)
        else $error("sample stalled with room in the pipeline");
`endif

endmodule

/* design/lscp_cfg_regs.sv */
`timescale 1ns / 1ps

module lscp_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [lscp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lscp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output lscp_pkg::cfg_t                     cfg
);
    import lscp_pkg::*;

    cfg_t cfg_reg;

    assign cfg = cfg_reg;

    // Unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trip_delay           <= 16'd10;
            cfg_reg.fault_threshold_high <= 8'd200;
            cfg_reg.open_threshold_high  <= 8'd5;
            cfg_reg.fault_threshold_low  <= 8'd200;
            cfg_reg.open_threshold_low   <= 8'd5;
            cfg_reg.restart_mask         <= 16'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TRIP_DELAY:    cfg_reg.trip_delay           <= cfg_data;
                REG_FAULT_TH_HIGH: cfg_reg.fault_threshold_high <= cfg_data[7:0];
                REG_OPEN_TH_HIGH:  cfg_reg.open_threshold_high  <= cfg_data[7:0];
                REG_FAULT_TH_LOW:  cfg_reg.fault_threshold_low  <= cfg_data[7:0];
                REG_OPEN_TH_LOW:   cfg_reg.open_threshold_low   <= cfg_data[7:0];
                REG_RESTART_MASK:  cfg_reg.restart_mask         <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

/* design/lscp_step.sv */
`timescale 1ns / 1ps

module lscp_step (
    input  lscp_pkg::cfg_t                     cfg,
    input  lscp_pkg::sample_t                  item,
    input  logic [2:0]                         cur_mode,
    input  logic [lscp_pkg::TICK_BITS-1:0]     cur_ticks,
    input  logic                               cur_err,
    output lscp_pkg::upd_t                     upd
);
    import lscp_pkg::*;

    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    logic [7:0]           fault_th;
    logic [7:0]           open_th;
    logic                 restart;
    logic                 over_fault;
    logic [TICK_BITS-1:0] ticks_inc;
    logic                 trip;

    always_comb
    begin
        fault_th   = item.low_current_class ? cfg.fault_threshold_low
                                            : cfg.fault_threshold_high;
        open_th    = item.low_current_class ? cfg.open_threshold_low
                                            : cfg.open_threshold_high;
        restart    = cfg.restart_mask[item.channel];
        over_fault = item.current > fault_th;
        // saturate at all ones
        ticks_inc  = (cur_ticks == TICK_MAX) ? cur_ticks : cur_ticks + 1'b1;
        trip       = CMP_W'(ticks_inc) > CMP_W'(cfg.trip_delay);
    end

    always_comb
    begin
        upd.mode   = cur_mode;
        upd.action = ACT_NONE;
        upd.ticks  = cur_ticks;
        upd.err    = cur_err;
        unique case (cur_mode)
            MODE_OFF:
            begin
                if (item.enable_request && !cur_err)
                begin
                    upd.mode   = MODE_ON;
                    upd.action = ACT_ON;
                end
                else if (over_fault)
                begin
                    upd.mode   = MODE_FAULT;
                    upd.action = ACT_FAULT;
                    upd.err    = 1'b1;
                end
                else if (item.current > open_th)
                begin
                    upd.mode   = MODE_OPEN;
                    upd.action = ACT_OPEN;
                end
            end
            MODE_ON:
            begin
                if (!item.enable_request)
                begin
                    upd.mode   = MODE_OFF;
                    upd.action = ACT_OFF;
                    upd.ticks  = '0;
                end
                else if (over_fault)
                begin
                    upd.mode   = MODE_FAULT;
                    upd.action = ACT_FAULT;
                    upd.err    = 1'b1;
                end
                else if (item.current > item.fuse_limit)
                begin
                    upd.ticks = ticks_inc;
                    if (trip)
                    begin
                        upd.mode   = MODE_OC;
                        upd.action = ACT_OC;
                        upd.err    = 1'b1;
                    end
                end
            end
            MODE_OC:
            begin
                if (!item.enable_request)
                begin
                    upd.mode   = MODE_OFF;
                    upd.action = ACT_OFF;
                end
                else if (restart)
                begin
                    upd.mode   = MODE_ON;
                    upd.action = ACT_ON;
                end
            end
            MODE_FAULT:
            begin
                if (restart)
                begin
                    upd.mode   = MODE_CLEAR;
                    upd.action = ACT_CLEAR;
                    upd.err    = 1'b0;
                end
            end
            MODE_CLEAR:
            begin
                if (over_fault)
                begin
                    upd.mode   = MODE_FAULT;
                    upd.action = ACT_FAULT;
                    upd.err    = 1'b1;
                end
            end
            MODE_OPEN:
            begin
                if (item.current < open_th)
                begin
                    upd.mode   = MODE_OFF;
                    upd.action = ACT_OFF;
                end
            end
            default:
            begin
                upd.mode = cur_mode;
            end
        endcase
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

// Protection state machine check: every sample word that the block takes is run
// through a shadow of the per-channel state machine here, and each result word
// must match the oldest prediction. The shadow mirrors every accepted register
// write.

module tb;

    import lscp_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 186;
    localparam int RAND_PHASES = 7;
    localparam int MAX_REPORTS = 100;

    // Indexes outside the register map: the block must drop writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    sample_t               sample = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the block: settings and per-channel state
    cfg_t                 shadow_cfg;
    logic [2:0]           ch_mode  [CHANNELS];
    logic [TICK_BITS-1:0] ch_ticks [CHANNELS];
    logic [CHANNELS-1:0]  ch_err;

    sample_t sample_backlog[$];
    result_t expected_results[$];

    int idle_pct = 0;
    int send_gap = 0;
    int stall_left = 0;
    int cycles = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int action_count [8];

    load_switch_channel_protection u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow state machine
    // ------------------------------------------------------------------

    // Take one sample word, advance the channel it names, return the result word.
    function automatic result_t protect_step(sample_t s);
        result_t             r;
        logic [7:0]          fault_lvl;
        logic [7:0]          open_lvl;
        logic [2:0]          m;
        logic [2:0]          act;
        logic                retry;
        logic [CH_IDX_W-1:0] c;
        c         = s.channel;
        fault_lvl = s.low_current_class ? shadow_cfg.fault_threshold_low
                                        : shadow_cfg.fault_threshold_high;
        open_lvl  = s.low_current_class ? shadow_cfg.open_threshold_low
                                        : shadow_cfg.open_threshold_high;
        retry     = shadow_cfg.restart_mask[c];
        m         = ch_mode[c];
        act       = ACT_NONE;
        case (m)
            MODE_OFF:
                if (s.enable_request && !ch_err[c])
                begin
                    m   = MODE_ON;
                    act = ACT_ON;
                end
                else if (s.current > fault_lvl)
                begin
                    m         = MODE_FAULT;
                    act       = ACT_FAULT;
                    ch_err[c] = 1'b1;
                end
                else if (s.current > open_lvl)
                begin
                    m   = MODE_OPEN;
                    act = ACT_OPEN;
                end
            MODE_ON:
                if (!s.enable_request)
                begin
                    // the only place the tick counter is cleared
                    ch_ticks[c] = '0;
                    m           = MODE_OFF;
                    act         = ACT_OFF;
                end
                else if (s.current > fault_lvl)
                begin
                    m         = MODE_FAULT;
                    act       = ACT_FAULT;
                    ch_err[c] = 1'b1;
                end
                else if (s.current > s.fuse_limit)
                begin
                    // saturate rather than wrap
                    if (ch_ticks[c] != {TICK_BITS{1'b1}})
                        ch_ticks[c] = ch_ticks[c] + 1'b1;
                    if (ch_ticks[c] > shadow_cfg.trip_delay)
                    begin
                        m         = MODE_OC;
                        act       = ACT_OC;
                        ch_err[c] = 1'b1;
                    end
                end
            MODE_OC:
                if (!s.enable_request)
                begin
                    m   = MODE_OFF;
                    act = ACT_OFF;
                end
                else if (retry)
                begin
                    m   = MODE_ON;
                    act = ACT_ON;
                end
            MODE_FAULT:
                if (retry)
                begin
                    m         = MODE_CLEAR;
                    act       = ACT_CLEAR;
                    ch_err[c] = 1'b0;
                end
            MODE_CLEAR:
                if (s.current > fault_lvl)
                begin
                    m         = MODE_FAULT;
                    act       = ACT_FAULT;
                    ch_err[c] = 1'b1;
                end
            MODE_OPEN:
                if (s.current < open_lvl)
                begin
                    m   = MODE_OFF;
                    act = ACT_OFF;
                end
            default: ;
        endcase
        ch_mode[c]      = m;
        r.channel_out   = s.channel;
        r.mode          = m;
        r.action        = act;
        r.drive_on      = (m == MODE_ON);
        r.channel_error = ch_err[c];
        r.any_error     = |ch_err;
        return r;
    endfunction

    // Mirror one accepted register write; unknown indexes are dropped.
    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TRIP_DELAY:    shadow_cfg.trip_delay           = data;
            REG_FAULT_TH_HIGH: shadow_cfg.fault_threshold_high = data[7:0];
            REG_OPEN_TH_HIGH:  shadow_cfg.open_threshold_high  = data[7:0];
            REG_FAULT_TH_LOW:  shadow_cfg.fault_threshold_low  = data[7:0];
            REG_OPEN_TH_LOW:   shadow_cfg.open_threshold_low   = data[7:0];
            REG_RESTART_MASK:  shadow_cfg.restart_mask         = data;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatches++;
        // keep the log readable when something is badly broken
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
                               logic [3:0] ch);
        if (got !== want)
            report_mismatch($sformatf("channel %0d %s got %0h want %0h",
                                      ch, name, got, want));
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result word for channel %0d with nothing outstanding",
                                      got.channel_out));
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        action_count[want.action]++;
        check_field("channel_out", 32'(got.channel_out), 32'(want.channel_out),
                    want.channel_out);
        check_field("mode", 32'(got.mode), 32'(want.mode), want.channel_out);
        check_field("action", 32'(got.action), 32'(want.action), want.channel_out);
        check_field("drive_on", 32'(got.drive_on), 32'(want.drive_on), want.channel_out);
        check_field("channel_error", 32'(got.channel_error), 32'(want.channel_error),
                    want.channel_out);
        check_field("any_error", 32'(got.any_error), 32'(want.any_error),
                    want.channel_out);
    endtask

    // ------------------------------------------------------------------
    // Sample driver: feed words from the backlog, hold while stalled
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : sample_driver
        logic    next_valid;
        sample_t next_word;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            next_valid = sample_valid;
            next_word  = sample;
            // a word moves on this edge: predict it now, in acceptance order
            if (sample_valid && !sample_stall)
            begin
                expected_results.push_back(protect_step(sample));
                samples_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (sample_backlog.size() != 0)
                begin
                    // open a random gap, or present the next word
                    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    begin
                        send_gap = $urandom_range(0, 3);
                    end
                    else
                    begin
                        next_word  = sample_backlog.pop_front();
                        next_valid = 1'b1;
                    end
                end
            end
            sample_valid <= next_valid;
            sample       <= next_word;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each accepted word, stall in random bursts
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : result_monitor
        logic next_stall;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            next_stall = 1'b0;
            if (stall_left > 0)
            begin
                stall_left--;
                next_stall = 1'b1;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(0, 3);
                next_stall = 1'b1;
            end
            result_stall <= next_stall;
        end
    end

    // Watchdog: drop the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_sample(int ch, int cur, bit en, bit lowc, int lim);
        sample_t s;
        s.channel           = 4'(ch);
        s.current           = 8'(cur);
        s.enable_request    = en;
        s.low_current_class = lowc;
        s.fuse_limit        = 8'(lim);
        sample_backlog.push_back(s);
    endtask

    // Wait until every word has gone through and the pipeline has emptied.
    // Ends just after a rising edge, ready for register writes.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || sample_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Present one register write and hold it until the block takes it.
    // Called just after a rising edge; leaves cfg_valid high for the caller to drop.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_setting(idx, data);
    endtask

    // Write the whole register map; upper bits of the 8-bit registers carry noise.
    task automatic write_settings(int inrush, int fth_h, int oth_h, int fth_l, int oth_l,
                                  int mask);
        cfg_write(REG_TRIP_DELAY,    16'(inrush));
        cfg_write(REG_FAULT_TH_HIGH, {8'($urandom), 8'(fth_h)});
        cfg_write(REG_OPEN_TH_HIGH,  {8'($urandom), 8'(oth_h)});
        cfg_write(REG_FAULT_TH_LOW,  {8'($urandom), 8'(fth_l)});
        cfg_write(REG_OPEN_TH_LOW,   {8'($urandom), 8'(oth_l)});
        cfg_write(REG_RESTART_MASK,  16'(mask));
        cfg_write(REG_SPARE_A,       16'($urandom));
        cfg_write(REG_SPARE_B,       16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // A level a step either side of a threshold, clipped to the field range
    function automatic int near_level(int lvl);
        int v;
        v = lvl + $urandom_range(0, 2) - 1;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v;
    endfunction

    // Mostly enabled words on a few busy channels, so that channels run on,
    // build up ticks and trip; currents cluster round the active thresholds.
    task automatic add_random_sample();
        int  ch;
        int  cur;
        int  lim;
        bit  lowc;
        bit  en;
        int  fault_lvl;
        int  open_lvl;
        ch        = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
        lowc      = 1'($urandom_range(0, 1));
        en        = ($urandom_range(0, 9) < 8);
        fault_lvl = lowc ? int'(shadow_cfg.fault_threshold_low)
                         : int'(shadow_cfg.fault_threshold_high);
        open_lvl  = lowc ? int'(shadow_cfg.open_threshold_low)
                         : int'(shadow_cfg.open_threshold_high);
        lim       = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, fault_lvl);
        case ($urandom_range(0, 6))
            0:       cur = $urandom_range(0, 255);
            1:       cur = near_level(fault_lvl);
            2:       cur = near_level(open_lvl);
            3:       cur = ($urandom_range(0, 1) != 0) ? 255 : 0;
            default: cur = near_level(lim + 1);
        endcase
        add_sample(ch, cur, en, lowc, lim);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        // mirror the register defaults and the cleared channel state
        shadow_cfg = '{trip_delay: 16'd10, fault_threshold_high: 8'd200,
                       open_threshold_high: 8'd5, fault_threshold_low: 8'd200,
                       open_threshold_low: 8'd5, restart_mask: 16'd0};
        ch_err = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            ch_mode[c]  = MODE_OFF;
            ch_ticks[c] = '0;
        end
        foreach (action_count[a])
            action_count[a] = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, on the reset defaults, with some gaps and stalls
        idle_pct = 20;
        @(negedge clk);
        add_sample(1, 6, 0, 0, 0);        // off, above open level: open load
        add_sample(1, 5, 0, 0, 0);        // open, at the level: hold
        add_sample(1, 4, 1, 0, 0);        // open, below the level: off
        add_sample(1, 200, 1, 0, 255);    // off, enabled: on
        add_sample(1, 200, 1, 0, 255);    // on, at the fault level: hold
        add_sample(1, 201, 1, 0, 255);    // on, above it: fault, error latched
        add_sample(1, 0, 1, 0, 255);      // fault with no retry: stuck
        add_sample(2, 255, 0, 1, 0);      // off, short on the low class: fault
        add_sample(3, 0, 1, 0, 0);        // on
        for (int i = 0; i < 11; i++)
            add_sample(3, 1, 1, 0, 0);    // eleventh over-limit sample trips
        add_sample(3, 255, 1, 1, 0);      // overcurrent, no retry: hold
        add_sample(3, 0, 0, 0, 0);        // overcurrent, disabled: off
        add_sample(3, 0, 1, 0, 0);        // error latched: stays off
        wait_drained();

        // Directed, with retry on every channel and a short inrush window
        idle_pct = 0;
        write_settings(2, 200, 5, 150, 20, 16'hFFFF);
        @(negedge clk);
        add_sample(1, 0, 0, 0, 0);        // fault, retry: clear-fault
        add_sample(1, 255, 0, 1, 0);      // clear-fault, short: fault again
        add_sample(1, 0, 0, 0, 0);        // and clear again
        add_sample(1, 150, 0, 1, 0);      // at the low-class level: hold
        add_sample(4, 0, 1, 0, 50);       // on
        for (int i = 0; i < 3; i++)
            add_sample(4, 51, 1, 0, 50);  // third one trips
        add_sample(4, 0, 1, 0, 50);       // overcurrent, retry: on again
        add_sample(4, 51, 1, 0, 50);      // ticks were kept: trips at once
        add_sample(4, 0, 0, 0, 50);       // overcurrent, disabled: off
        add_sample(5, 21, 0, 1, 0);       // open on the low class
        add_sample(5, 19, 0, 1, 0);       // back to off
        wait_drained();

        // Widest inrush window holds off the trip; narrow it to the count
        // already built up and the next over-limit sample must trip
        cfg_write(REG_TRIP_DELAY, 16'hFFFF);
        cfg_valid <= 1'b0;
        @(negedge clk);
        add_sample(6, 0, 1, 0, 0);
        for (int i = 0; i < 3; i++)
            add_sample(6, 100, 1, 0, 0);
        wait_drained();
        cfg_write(REG_TRIP_DELAY, 16'd3);
        cfg_valid <= 1'b0;
        @(negedge clk);
        add_sample(6, 100, 1, 0, 0);
        wait_drained();

        // Random phases: zero settings first, full-scale next, then mixed;
        // the last phase runs without gaps or stalls
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
                write_settings(0, 0, 0, 0, 0, 0);
            else if (p == 1)
                write_settings(16'hFFFF, 255, 255, 255, 255, 16'hFFFF);
            else
                write_settings(($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 4),
                               $urandom_range(100, 255), $urandom_range(0, 30),
                               $urandom_range(100, 255), $urandom_range(0, 30),
                               $urandom_range(0, 65535));
            idle_pct = (p == RAND_PHASES - 1) ? 0 : (p % 3) * 15;
            @(negedge clk);
            for (int i = 0; i < PHASE_WORDS; i++)
                add_random_sample();
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("%0d sample words sent, %0d result words checked, %0d mismatches",
                 samples_sent, results_checked, mismatches);
        $display("actions none %0d on %0d off %0d trip %0d open %0d fault %0d clear %0d",
                 action_count[ACT_NONE], action_count[ACT_ON], action_count[ACT_OFF],
                 action_count[ACT_OC], action_count[ACT_OPEN], action_count[ACT_FAULT],
                 action_count[ACT_CLEAR]);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
